// File: design/csh_pkg.sv
// Shared types and constants for the three-class slice histogram.
`default_nettype none

package csh_pkg;

   // Command codes
   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_BIN_COUNT   = 2'd0;
   localparam logic [1:0] CSR_BIN_SCALE   = 2'd1;
   localparam logic [1:0] CSR_LIGHT_LIMIT = 2'd2;
   localparam logic [1:0] CSR_HEAVY_LIMIT = 2'd3;

   // Configuration reset values
   localparam logic [8:0]  BIN_COUNT_RESET   = 9'd256;
   localparam logic [31:0] BIN_SCALE_RESET   = 32'd16777216;
   localparam logic [6:0]  LIGHT_LIMIT_RESET = 7'd7;
   localparam logic [6:0]  HEAVY_LIMIT_RESET = 7'd9;

   // Charge classes
   localparam logic [1:0] CLS_LIGHT  = 2'd0;
   localparam logic [1:0] CLS_MIDDLE = 2'd1;
   localparam logic [1:0] CLS_HEAVY  = 2'd2;

   // Reported count widths and their saturation limits
   localparam int OUT_CNT_WIDTH = 20;
   localparam int OUT_TOT_WIDTH = 22;
   localparam logic [OUT_CNT_WIDTH-1:0] OUT_CNT_MAX = 20'hFFFFF;
   localparam logic [OUT_TOT_WIDTH-1:0] OUT_TOT_MAX = 22'h3FFFFF;

   // Bin product: Q16.16 times Q8.24, bin taken from bit 40 up
   localparam int BIN_SHIFT = 40;
   localparam int BIN_WIDTH = 24;

   typedef struct packed {
      logic        command;
      logic [31:0] position_z;
      logic [6:0]  charge;
      logic [7:0]  bin_index;
   } req_type;

   typedef struct packed {
      logic [7:0]               read_bin;
      logic [OUT_CNT_WIDTH-1:0] light_count;
      logic [OUT_CNT_WIDTH-1:0] middle_count;
      logic [OUT_CNT_WIDTH-1:0] heavy_count;
      logic [OUT_TOT_WIDTH-1:0] total_count;
   } rsp_type;

   // Operation handed to the counter store
   typedef struct packed {
      logic       valid;
      logic       is_read;
      logic       hit;
      logic [1:0] cls;
   } store_op_type;

endpackage

`default_nettype wire

// File: design/csh_bin_store.sv
// Counter store: bin memory with read-modify-write, forwarding and clearing pass.
`default_nettype none

module csh_bin_store
   import csh_pkg::*;
#(
   parameter int MAX_BINS    = 256,
   parameter int COUNT_WIDTH = 20
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire store_op_type                 op_in,
   input  wire logic [$clog2(MAX_BINS)-1:0]  addr_in,
   output logic                              clearing,
   output store_op_type                      op_out,
   output logic [3*COUNT_WIDTH-1:0]          counts_out
);

   localparam int ADDR_WIDTH = $clog2(MAX_BINS);
   localparam int DATA_WIDTH = 3 * COUNT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [ADDR_WIDTH-1:0]  LAST_ADDR = ADDR_WIDTH'(MAX_BINS - 1);

   logic [DATA_WIDTH-1:0] mem [MAX_BINS];

   logic                  clearing_ff;
   logic [ADDR_WIDTH-1:0] clear_ptr_ff;
   store_op_type          op_c_ff;
   logic [ADDR_WIDTH-1:0] addr_c_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  fwd_valid_ff;
   logic [ADDR_WIDTH-1:0] fwd_addr_ff;
   logic [DATA_WIDTH-1:0] fwd_data_ff;

   logic [DATA_WIDTH-1:0]  cur_data;
   logic [COUNT_WIDTH-1:0] cur_cnt [3];
   logic [COUNT_WIDTH-1:0] new_cnt [3];
   logic [DATA_WIDTH-1:0]  new_data;
   logic                   item_wr;
   logic                   wr_en;
   logic [ADDR_WIDTH-1:0]  wr_addr;
   logic [DATA_WIDTH-1:0]  wr_data;

   // Take the previous write when it hit the address read alongside it
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == addr_c_ff)) begin
         cur_data = fwd_data_ff;
      end else begin
         cur_data = rd_data_ff;
      end
   end

   // Bump the selected class with saturation, or zero the bin on a read
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cur_cnt[i] = cur_data[i*COUNT_WIDTH +: COUNT_WIDTH];
         if (op_c_ff.is_read) begin
            new_cnt[i] = '0;
         end else if ((op_c_ff.cls == 2'(i)) && (cur_cnt[i] != CNT_MAX)) begin
            new_cnt[i] = cur_cnt[i] + 1'b1;
         end else begin
            new_cnt[i] = cur_cnt[i];
         end
         new_data[i*COUNT_WIDTH +: COUNT_WIDTH] = new_cnt[i];
      end
   end

   // Select the write: clearing pass first, then item write-back
   assign item_wr = op_c_ff.valid && op_c_ff.hit;
   assign wr_en   = clearing_ff || item_wr;
   assign wr_addr = clearing_ff ? clear_ptr_ff : addr_c_ff;
   assign wr_data = clearing_ff ? '0 : new_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[addr_in];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_ptr_ff  <= '0;
         op_c_ff       <= '0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         if (clearing_ff) begin
            if (clear_ptr_ff == LAST_ADDR) begin
               clearing_ff <= 1'b0;
            end else begin
               clear_ptr_ff <= clear_ptr_ff + 1'b1;
            end
         end
         op_c_ff       <= op_in;
         fwd_valid_ff  <= item_wr && !clearing_ff;
      end
   end

   // Payload stage
   always_ff @(posedge clock) begin
      addr_c_ff       <= addr_in;
      fwd_addr_ff     <= addr_c_ff;
      fwd_data_ff     <= new_data;
   end

   assign clearing   = clearing_ff;
   assign op_out     = op_c_ff;
   assign counts_out = op_c_ff.hit ? cur_data : '0;

endmodule

`default_nettype wire

// File: design/class_split_slice_histogram.sv
// Top level of the three-class slice histogram.
//
// Add commands (command 0) bin a particle by floor(position_z * bin_scale) and
// bump its light, middle or heavy counter; read commands (command 1) return the
// three counts of bin_index and their sum, then zero that bin. One command is
// accepted every cycle while busy is low; a read's result appears on rsp_valid
// after the input register, multiplier register, memory read register, count
// register and result register. rsp_valid is a one-cycle strobe and the
// receiver cannot hold a result off, so it must take each result in the cycle
// it is shown. Adds give no result.
// The counter memory is updated by a read-modify-write with one forwarding
// register, so back-to-back commands on the same bin see each other. After
// reset, busy stays high while a clearing pass zeroes the memory one bin per
// cycle; configuration writes are taken at any time, but make them only while
// no command is in flight.
`default_nettype none

module class_split_slice_histogram
   import csh_pkg::*;
#(
   parameter int MAX_BINS    = 256,
   parameter int COUNT_WIDTH = 20
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int ADDR_WIDTH = $clog2(MAX_BINS);
   localparam logic [BIN_WIDTH-1:0] MAX_BINS_W = BIN_WIDTH'(MAX_BINS);

   // Configuration registers
   logic [8:0]  bin_count_ff;
   logic [31:0] bin_scale_ff;
   logic [6:0]  light_limit_ff;
   logic [6:0]  heavy_limit_ff;

   // Input stage
   logic    a_valid_ff;
   req_type a_req_ff;
   logic    accept;

   // Bin stage
   logic                 b_valid_ff;
   logic                 b_is_read_ff;
   logic [1:0]           b_cls_ff;
   logic [7:0]           b_idx_ff;
   logic [BIN_WIDTH-1:0] b_bin_ff;
   logic [1:0]           a_cls;
   logic [63:0]          a_product;

   logic [BIN_WIDTH-1:0]  b_addr;
   logic                  b_hit;
   store_op_type          b_op;
   store_op_type          c_op;
   logic [7:0]            c_idx_ff;
   logic [3*COUNT_WIDTH-1:0] c_counts;

   // Count stage
   logic                   d_valid_ff;
   logic [7:0]             d_bin_ff;
   logic [COUNT_WIDTH-1:0] d_cnt_ff [3];
   logic [33:0]            d_ext [3];
   logic [33:0]            d_sum;
   rsp_type                d_rsp;

   // Result stage
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic store_clearing;

   assign busy      = store_clearing;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Hold configuration; write on each csr transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff   <= BIN_COUNT_RESET;
         bin_scale_ff   <= BIN_SCALE_RESET;
         light_limit_ff <= LIGHT_LIMIT_RESET;
         heavy_limit_ff <= HEAVY_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BIN_COUNT:   bin_count_ff   <= csr_data[8:0];
            CSR_BIN_SCALE:   bin_scale_ff   <= csr_data;
            CSR_LIGHT_LIMIT: light_limit_ff <= csr_data[6:0];
            CSR_HEAVY_LIMIT: heavy_limit_ff <= csr_data[6:0];
         endcase
      end
   end

   // Scale the position and classify the charge
   assign a_product = 64'(a_req_ff.position_z) * 64'(bin_scale_ff);

   always_comb begin
      priority if (a_req_ff.charge < light_limit_ff) begin
         a_cls = CLS_LIGHT;
      end else if (a_req_ff.charge < heavy_limit_ff) begin
         a_cls = CLS_MIDDLE;
      end else begin
         a_cls = CLS_HEAVY;
      end
   end

   // Pick the bin address and check it against the store and, for adds, the bin count
   always_comb begin
      if (b_is_read_ff) begin
         b_addr = BIN_WIDTH'(b_idx_ff);
         b_hit  = b_addr < MAX_BINS_W;
      end else begin
         b_addr = b_bin_ff;
         b_hit  = (b_addr < BIN_WIDTH'(bin_count_ff)) && (b_addr < MAX_BINS_W);
      end
      b_op.valid   = b_valid_ff;
      b_op.is_read = b_is_read_ff;
      b_op.hit     = b_hit;
      b_op.cls     = b_cls_ff;
   end

   csh_bin_store #(
      .MAX_BINS    (MAX_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .op_in      (b_op),
      .addr_in    (b_addr[ADDR_WIDTH-1:0]),
      .clearing   (store_clearing),
      .op_out     (c_op),
      .counts_out (c_counts)
   );

   // Saturate the reported counts and the total
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_ext[i] = 34'(d_cnt_ff[i]);
      end
      d_sum = d_ext[0] + d_ext[1] + d_ext[2];
      d_rsp.read_bin     = d_bin_ff;
      d_rsp.light_count  = (d_ext[0] > 34'(OUT_CNT_MAX)) ? OUT_CNT_MAX
                                                          : d_ext[0][OUT_CNT_WIDTH-1:0];
      d_rsp.middle_count = (d_ext[1] > 34'(OUT_CNT_MAX)) ? OUT_CNT_MAX
                                                          : d_ext[1][OUT_CNT_WIDTH-1:0];
      d_rsp.heavy_count  = (d_ext[2] > 34'(OUT_CNT_MAX)) ? OUT_CNT_MAX
                                                          : d_ext[2][OUT_CNT_WIDTH-1:0];
      d_rsp.total_count  = (d_sum > 34'(OUT_TOT_MAX)) ? OUT_TOT_MAX
                                                       : d_sum[OUT_TOT_WIDTH-1:0];
   end

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= accept;
         b_valid_ff   <= a_valid_ff;
         d_valid_ff   <= c_op.valid && c_op.is_read;
         rsp_valid_ff <= d_valid_ff;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      if (accept) begin
         a_req_ff <= req_data;
      end
      b_is_read_ff <= (a_req_ff.command == CMD_READ);
      b_cls_ff     <= a_cls;
      b_idx_ff     <= a_req_ff.bin_index;
      b_bin_ff     <= a_product[BIN_SHIFT +: BIN_WIDTH];
      c_idx_ff     <= b_idx_ff;
      d_bin_ff     <= c_idx_ff;
      for (int i = 0; i < 3; i++) begin
         d_cnt_ff[i] <= c_counts[i*COUNT_WIDTH +: COUNT_WIDTH];
      end
      rsp_data_ff  <= d_rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: design/csh_checker.sv
// Port-level checks for the slice histogram, bound to the top level.
`default_nettype none

module csh_checker
   import csh_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   logic read_xfer;

   assign read_xfer = start && !busy && (req_data.command == CMD_READ);

   // Busy rises only out of reset
   assert property (@(posedge clock) $rose(busy) |-> $past(reset))
      else $error("busy rose outside of reset");

   // Every result comes from an earlier read transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(read_xfer, 5))
      else $error("result without a matching read transfer");

   // Every read transfer gives a result unless reset comes in between
   assert property (@(posedge clock) disable iff (reset)
      read_xfer |-> ##5 (rsp_valid || $past(reset, 1) || $past(reset, 2)
                         || $past(reset, 3) || $past(reset, 4)))
      else $error("read transfer lost its result");

   // The result names the bin that was read
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.read_bin == $past(req_data.bin_index, 5)))
      else $error("result bin does not match the read");

   // The total never falls below any class count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.total_count >= 22'(rsp_data.light_count))
                  && (rsp_data.total_count >= 22'(rsp_data.middle_count))
                  && (rsp_data.total_count >= 22'(rsp_data.heavy_count))))
      else $error("total below a class count");

endmodule

bind class_split_slice_histogram csh_checker u_checker (.*);

`default_nettype wire

// File: sim/class_split_slice_histogram_tb.sv
// Self-checking testbench for the three-class slice histogram with its own tally predictor.
module class_split_slice_histogram_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import csh_pkg::*;

   localparam int SLICES        = 256;
   localparam int SETTLE_CYCLES = 10;
   localparam int CYCLE_LIMIT   = 250000;
   localparam logic [19:0] TALLY_TOP = 20'hFFFFF;

   typedef struct packed {
      logic [19:0] light;
      logic [19:0] middle;
      logic [19:0] heavy;
   } tally_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   logic        busy;
   req_type     req_data  = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_BIN_COUNT;
   logic [31:0] csr_data  = '0;

   // Predictor state: per-slice tallies and a copy of the registers
   tally_type   slice_tally [SLICES];
   logic [8:0]  slices_in_use;
   logic [31:0] slice_scale;
   logic [6:0]  light_below;
   logic [6:0]  heavy_from;

   req_type command_queue [$];
   rsp_type pending_reports [$];

   int  idle_left      = 0;
   bit  sender_idles   = 1'b1;
   int  error_count    = 0;
   int  adds_taken     = 0;
   int  adds_dropped   = 0;
   int  reports_seen   = 0;
   int  settings_used  = 1;
   int  cycle_count    = 0;

   class_split_slice_histogram dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bin one add into the tallies, or report and clear one slice on a read
   task automatic tally_command(input req_type r);
      bit [63:0] product;
      bit [63:0] slice;
      rsp_type   report;
      tally_type t;
      bit [21:0] sum;
      if (r.command == CMD_ADD) begin
         product = 64'(r.position_z) * 64'(slice_scale);
         slice   = product >> BIN_SHIFT;
         adds_taken++;
         if (slice >= 64'(slices_in_use) || slice >= 64'(SLICES)) begin
            adds_dropped++;
         end else begin
            t = slice_tally[slice[7:0]];
            if (r.charge < light_below) begin
               if (t.light != TALLY_TOP) t.light++;
            end else if (r.charge < heavy_from) begin
               if (t.middle != TALLY_TOP) t.middle++;
            end else begin
               if (t.heavy != TALLY_TOP) t.heavy++;
            end
            slice_tally[slice[7:0]] = t;
         end
      end else begin
         t   = slice_tally[r.bin_index];
         sum = 22'(t.light) + 22'(t.middle) + 22'(t.heavy);
         report.read_bin     = r.bin_index;
         report.light_count  = t.light;
         report.middle_count = t.middle;
         report.heavy_count  = t.heavy;
         report.total_count  = (sum > OUT_TOT_MAX) ? OUT_TOT_MAX : sum;
         slice_tally[r.bin_index] = '0;
         pending_reports.push_back(report);
      end
   endtask

   // Driver: present queued commands, hold while busy, idle in random bursts
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
         foreach (slice_tally[i]) slice_tally[i] = '0;
      end else begin
         if (start && !busy) tally_command(req_data);
         if (start && busy) begin
            // hold the command until it is taken
         end else if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (command_queue.size() > 0) begin
            req_data <= command_queue.pop_front();
            start    <= 1'b1;
            if (sender_idles && $urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 18);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Track register writes for the predictor
   always @(posedge clock) begin
      if (reset) begin
         slices_in_use <= BIN_COUNT_RESET;
         slice_scale   <= BIN_SCALE_RESET;
         light_below   <= LIGHT_LIMIT_RESET;
         heavy_from    <= HEAVY_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BIN_COUNT:   slices_in_use <= csr_data[8:0];
            CSR_BIN_SCALE:   slice_scale   <= csr_data;
            CSR_LIGHT_LIMIT: light_below   <= csr_data[6:0];
            CSR_HEAVY_LIMIT: heavy_from    <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Monitor: compare each report with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected report for bin %0d", rsp_data.read_bin);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            reports_seen++;
            check_field("read_bin", 32'(want.read_bin), 32'(rsp_data.read_bin));
            check_field("light_count", 32'(want.light_count), 32'(rsp_data.light_count));
            check_field("middle_count", 32'(want.middle_count),
                        32'(rsp_data.middle_count));
            check_field("heavy_count", 32'(want.heavy_count), 32'(rsp_data.heavy_count));
            check_field("total_count", 32'(want.total_count), 32'(rsp_data.total_count));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("class_split_slice_histogram_tb: done, errors");
         $finish;
      end
   end

   task automatic queue_add(input logic [31:0] z, input logic [6:0] q);
      req_type r;
      r.command    = CMD_ADD;
      r.position_z = z;
      r.charge     = q;
      r.bin_index  = 8'($urandom);
      command_queue.push_back(r);
   endtask

   task automatic queue_read(input logic [7:0] b);
      req_type r;
      r.command    = CMD_READ;
      r.position_z = $urandom;
      r.charge     = 7'($urandom);
      r.bin_index  = b;
      command_queue.push_back(r);
   endtask

   // Mostly adds aimed at live slices, charges near the class limits, repeated bins
   task automatic queue_random(input int n);
      int        span;
      int        b;
      int        last_b;
      bit [39:0] frac;
      bit [63:0] z64;
      req_type   r;
      span   = (slices_in_use == 0) ? 4
             : ((slices_in_use > SLICES) ? SLICES : int'(slices_in_use));
      last_b = 0;
      repeat (n) begin
         r.position_z = $urandom;
         r.charge     = 7'($urandom);
         r.bin_index  = 8'($urandom);
         b = ($urandom_range(0, 4) == 0) ? last_b : $urandom_range(0, span + 1);
         if ($urandom_range(0, 9) < 3) begin
            r.command = CMD_READ;
            if ($urandom_range(0, 6) != 0) r.bin_index = (b > 255) ? 8'd255 : 8'(b);
         end else begin
            r.command = CMD_ADD;
            if (slice_scale != 0 && $urandom_range(0, 6) != 0) begin
               frac = {8'($urandom), 32'($urandom)};
               z64  = ((64'(b) << BIN_SHIFT) + 64'(frac)) / 64'(slice_scale);
               r.position_z = (z64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : z64[31:0];
            end
            if ($urandom_range(0, 2) != 0) begin
               case ($urandom_range(0, 3))
                  0: r.charge = light_below - 7'd1;
                  1: r.charge = light_below;
                  2: r.charge = heavy_from - 7'd1;
                  default: r.charge = heavy_from;
               endcase
            end
         end
         last_b = b;
         command_queue.push_back(r);
      end
   endtask

   // Wait until all commands are taken, all reports are in, and the pipe is empty
   task automatic wait_for_quiet();
      while (command_queue.size() != 0 || start || pending_reports.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_transfer(input logic [1:0] idx, input logic [31:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_registers(input logic [8:0] count, input logic [31:0] scale,
                                    input logic [6:0] light, input logic [6:0] heavy);
      @(posedge clock);
      csr_transfer(CSR_BIN_COUNT, 32'(count));
      csr_transfer(CSR_BIN_SCALE, scale);
      csr_transfer(CSR_LIGHT_LIMIT, 32'(light));
      csr_transfer(CSR_HEAVY_LIMIT, 32'(heavy));
      csr_valid <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: one slice per unit, light below 7, heavy from 9
      queue_add(32'h0000_0000, 7'd0);
      queue_add(32'h0000_0000, 7'd6);
      queue_add(32'h0000_0000, 7'd7);
      queue_add(32'h0000_0000, 7'd8);
      queue_add(32'h0000_0000, 7'd9);
      queue_add(32'h0000_0000, 7'd127);
      queue_add(32'h00FF_FFFF, 7'd3);
      queue_add(32'h0100_0000, 7'd3);
      queue_add(32'hFFFF_FFFF, 7'd127);
      queue_read(8'd0);
      queue_read(8'd0);
      queue_read(8'd255);
      // back-to-back on one slice exercises forwarding
      queue_add(32'h0005_8000, 7'd10);
      queue_add(32'h0005_8000, 7'd10);
      queue_add(32'h0005_8000, 7'd10);
      queue_read(8'd5);
      queue_add(32'h0005_8000, 7'd0);
      queue_read(8'd5);
      queue_read(8'd17);
      queue_random(340);
      wait_for_quiet();

      // Full scale, no light class
      program_registers(9'd256, 32'hFFFF_FFFF, 7'd0, 7'd127);
      queue_random(250);
      wait_for_quiet();

      // Zero bin count drops every add; limits crossed leave no middle class
      program_registers(9'd0, 32'h0080_0000, 7'd127, 7'd0);
      queue_read(8'd0);
      queue_add(32'h0000_0000, 7'd0);
      queue_add(32'h0000_0000, 7'd127);
      queue_read(8'd0);
      queue_random(60);
      wait_for_quiet();

      // Single slice, zero scale puts every particle in slice zero
      program_registers(9'd1, 32'h0000_0000, 7'd64, 7'd65);
      queue_random(200);
      wait_for_quiet();

      // Few slices: reads past the bin count pick up stale counts
      program_registers(9'd4, 32'h4000_0000, 7'd3, 7'd100);
      queue_random(250);
      wait_for_quiet();

      // Bin count past the store; random scale and limits
      program_registers(9'h1FF, $urandom_range(32'h0040_0000, 32'h0400_0000),
                        7'($urandom), 7'($urandom));
      queue_random(300);
      wait_for_quiet();

      // Closing stretch at full rate
      program_registers(9'd256, $urandom_range(32'h0080_0000, 32'h0200_0000),
                        7'($urandom_range(0, 63)), 7'($urandom_range(64, 127)));
      sender_idles = 1'b0;
      queue_random(150);
      wait_for_quiet();

      $display("Checked %0d bin reports against %0d adds (%0d out of range).",
               reports_seen, adds_taken, adds_dropped);
      $display("Used %0d register settings, from zero and single slices to full scale.",
               settings_used);
      if (error_count == 0)
         $display("class_split_slice_histogram_tb: done, clean");
      else
         $display("class_split_slice_histogram_tb: done, errors");
      $finish;
   end

endmodule
